// ----- rtl/core/lru_pkg.sv -----
package lru_pkg;

    localparam int ENTRIES = 16;
    localparam int IW      = $clog2(ENTRIES);
    localparam int CNTW    = $clog2(ENTRIES + 1);
    localparam int SW      = 4;
    localparam int CW      = (IW > SW) ? IW : SW;

    localparam logic MODE_TOUCH = 1'b0;
    localparam logic MODE_EVICT = 1'b1;

    typedef logic [IW-1:0] t_idx;
    typedef logic [SW-1:0] t_slot;

    typedef struct packed {
        logic we;
        t_idx waddr;
        t_idx wdata;
        logic re;
        t_idx raddr;
    } t_ram_req;

    typedef struct packed {
        logic  done;
        t_slot victim;
        logic  victim_valid;
    } t_res;

endpackage

// ----- rtl/core/lru_ram.sv -----
module lru_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lru_pkg::t_ram_req i_req,
    output lru_pkg::t_idx     o_rdata
);

    lru_pkg::t_idx                  r_mem [lru_pkg::ENTRIES];
    logic [lru_pkg::ENTRIES-1:0]    r_vld;
    lru_pkg::t_idx                  r_rdata;
    lru_pkg::t_idx                  r_raddr;
    logic                           r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
            r_raddr <= i_req.raddr;
        end
    end

    // unwritten places read back as their own index (identity order)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvld <= r_vld[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : r_raddr;

endmodule

// ----- rtl/core/lru_seq.sv -----
module lru_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_mode,
    input  lru_pkg::t_slot    i_slot,
    output lru_pkg::t_ram_req o_req,
    input  lru_pkg::t_idx     i_rdata,
    input  logic              i_out_free,
    output lru_pkg::t_res     o_res
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_FIX   = 5'b00100,
        ST_EVICT = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    lru_pkg::t_idx             r_head, n_head;
    logic [lru_pkg::CNTW-1:0]  r_pos, n_pos;
    lru_pkg::t_idx             r_daddr, n_daddr;
    lru_pkg::t_idx             r_paddr, n_paddr;
    lru_pkg::t_slot            r_slot, n_slot;
    lru_pkg::t_slot            r_victim, n_victim;
    logic                      r_found, n_found;
    logic                      r_evict, n_evict;

    lru_pkg::t_idx             w_pos;
    logic [lru_pkg::IW:0]      w_sum;
    lru_pkg::t_idx             w_place;
    logic                      w_match;
    logic                      w_last;

    // shared ring address unit: (head + pos) mod ENTRIES
    always_comb begin
        case (r_state)
            ST_EVICT: w_pos = lru_pkg::IW'(1);
            ST_SCAN:  w_pos = r_pos[lru_pkg::IW-1:0];
            default:  w_pos = '0;
        endcase
        w_sum = {1'b0, r_head} + {1'b0, w_pos};
        if (w_sum >= (lru_pkg::IW+1)'(lru_pkg::ENTRIES)) begin
            w_place = lru_pkg::IW'(w_sum - (lru_pkg::IW+1)'(lru_pkg::ENTRIES));
        end else begin
            w_place = lru_pkg::IW'(w_sum);
        end
    end

    assign w_match = (lru_pkg::CW'(i_rdata) == lru_pkg::CW'(r_slot));
    assign w_last  = (r_pos == lru_pkg::CNTW'(lru_pkg::ENTRIES));

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_pos    = r_pos;
        n_daddr  = r_daddr;
        n_paddr  = r_paddr;
        n_slot   = r_slot;
        n_victim = r_victim;
        n_found  = r_found;
        n_evict  = r_evict;
        o_req    = '0;
        o_res.done         = 1'b0;
        o_res.victim       = r_evict ? r_victim : '0;
        o_res.victim_valid = r_evict;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = w_place;
                    n_slot      = i_slot;
                    n_daddr     = w_place;
                    n_found     = 1'b0;
                    n_pos       = lru_pkg::CNTW'(1);
                    n_evict     = (i_mode == lru_pkg::MODE_EVICT);
                    n_state     = (i_mode == lru_pkg::MODE_EVICT) ? ST_EVICT : ST_SCAN;
                end
            end
            ST_EVICT: begin
                n_victim = lru_pkg::SW'(i_rdata);
                n_head   = w_place;
                n_state  = ST_DONE;
            end
            ST_SCAN: begin
                // read ahead one place; past the match each beat moves up one place
                if (!w_last) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = w_place;
                    n_pos       = r_pos + lru_pkg::CNTW'(1);
                    n_daddr     = w_place;
                    n_paddr     = r_daddr;
                end
                if (r_found) begin
                    o_req.we    = 1'b1;
                    o_req.waddr = r_paddr;
                    o_req.wdata = i_rdata;
                end else if (w_match) begin
                    n_found = 1'b1;
                end
                if (w_last) begin
                    n_state = (r_found || w_match) ? ST_FIX : ST_DONE;
                end
            end
            ST_FIX: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_daddr;
                o_req.wdata = lru_pkg::IW'(r_slot);
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                o_res.done = i_out_free;
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_daddr  <= n_daddr;
        r_paddr  <= n_paddr;
        r_slot   <= n_slot;
        r_victim <= n_victim;
        r_found  <= n_found;
        r_evict  <= n_evict;
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

// ----- rtl/core/lru_order_list.sv -----
// LRU order list: least-recently-used order of ENTRIES slot numbers.
// Input channel (i_valid / o_stall, fields i_mode, i_slot): a beat with
// mode touch moves i_slot to the most recent end; mode evict returns the
// least recent slot and makes it the most recent one.
// Output channel (o_valid / i_stall, fields o_victim, o_victim_valid): one
// beat per input beat, in order. Touch gives victim zero, victim_valid zero.
// A touch walks the whole ring through the order memory (one read and one
// write port) and the shared ring address unit, then writes the slot at the
// most recent end when it is held; an evict needs one memory read. Either
// way the next beat is taken only once the result has gone to the output
// register.
// o_stall is high from acceptance until the result is loaded into the output
// register. While the receiver stalls, the output beat holds, the next item
// is still taken and worked, and its result waits until the register frees.
// Synchronous reset restores the identity order with head 0 at once.
module lru_order_list (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_mode,
    input  logic [3:0]          i_slot,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [3:0]          o_victim,
    output logic                o_victim_valid
);

    lru_pkg::t_ram_req  w_ram_req;
    lru_pkg::t_idx      w_rdata;
    lru_pkg::t_res      w_res;
    logic               w_out_free;

    logic               r_out_valid;
    lru_pkg::t_slot     r_victim;
    logic               r_victim_valid;

    lru_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ram_req),
        .o_rdata (w_rdata)
    );

    lru_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_slot     (i_slot),
        .o_req      (w_ram_req),
        .i_rdata    (w_rdata),
        .i_out_free (w_out_free),
        .o_res      (w_res)
    );

    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.done) begin
            r_victim       <= w_res.victim;
            r_victim_valid <= w_res.victim_valid;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_victim       = r_victim;
    assign o_victim_valid = r_victim_valid;

`ifndef SYNTHESIS
    a_touch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_victim_valid |-> o_victim == 4'd0)
        else $error("touch beat with nonzero victim");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted beat did not start the sequencer");

    a_write_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_req.we |-> o_stall)
        else $error("order memory written while idle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> (!r_out_valid || !i_stall))
        else $error("result loaded over an untaken beat");
`endif

endmodule

// ----- verif/lru_order_checker.sv -----
module lru_order_checker
    import lru_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_mode,
    input  logic [3:0] i_slot,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [3:0] i_victim,
    input  logic       i_victim_valid,
    output int         o_errors,
    output int         o_pending
);

    typedef struct packed {
        t_slot victim;
        logic  victim_valid;
    } lru_outcome_t;

    t_idx         lru_ring [ENTRIES];
    t_idx         ring_head;
    lru_outcome_t victim_q [$];
    lru_outcome_t want;
    int           err_cnt;

    initial begin
        err_cnt   = 0;
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic int ring_place(int pos);
        return (int'(ring_head) + pos) % ENTRIES;
    endfunction

    function automatic lru_outcome_t predict_access(logic mode, t_slot slot);
        lru_outcome_t res;
        int           pos;
        res = '0;
        pos = -1;
        if (mode == MODE_EVICT) begin
            res.victim       = t_slot'(lru_ring[ring_head]);
            res.victim_valid = 1'b1;
            ring_head        = t_idx'((int'(ring_head) + 1) % ENTRIES);
        end else begin
            for (int p = 0; p < ENTRIES; p++) begin
                if (pos < 0 && int'(lru_ring[ring_place(p)]) == int'(slot)) begin
                    pos = p;
                end
            end
            // slot not held: order unchanged
            if (pos >= 0) begin
                for (int k = pos; k + 1 < ENTRIES; k++) begin
                    lru_ring[ring_place(k)] = lru_ring[ring_place(k + 1)];
                end
                lru_ring[ring_place(ENTRIES - 1)] = t_idx'(slot);
            end
        end
        return res;
    endfunction

    task automatic flag_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                lru_ring[i] = t_idx'(i);
            end
            ring_head = '0;
            victim_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (victim_q.size() == 0) begin
                    flag_error($sformatf("beat with nothing pending: victim %0d valid %0b",
                                         i_victim, i_victim_valid));
                end else begin
                    want = victim_q.pop_front();
                    if (i_victim !== want.victim) begin
                        flag_error($sformatf("victim expected %0d got %0d",
                                             want.victim, i_victim));
                    end
                    if (i_victim_valid !== want.victim_valid) begin
                        flag_error($sformatf("victim_valid expected %0b got %0b",
                                             want.victim_valid, i_victim_valid));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                victim_q.push_back(predict_access(i_mode, t_slot'(i_slot)));
            end
        end
        o_errors  <= err_cnt;
        o_pending <= victim_q.size();
    end

endmodule

// ----- verif/tb_lru_order_list.sv -----
module tb_lru_order_list;
    import lru_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 475;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 40;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_mode  = 1'b0;
    logic [3:0] i_slot  = 4'd0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [3:0] o_victim;
    logic       o_victim_valid;

    int errors;
    int pending;
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_reqs  = 0;
    int hold_seen  = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    lru_order_list dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_slot         (i_slot),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_victim       (o_victim),
        .o_victim_valid (o_victim_valid)
    );

    lru_order_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_mode         (i_mode),
        .i_slot         (i_slot),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_victim       (o_victim),
        .i_victim_valid (o_victim_valid),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stall, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(0, 99) < recv_stall);
        end
    end

    task automatic send_beat(logic mode, t_slot slot);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            i_mode  <= 1'($urandom);
            i_slot  <= 4'($urandom);
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_slot  <= slot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic run_random(int n_items);
        int    sent;
        int    kind;
        int    len;
        t_slot s;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            s    = t_slot'($urandom);
            if (kind < 6) begin
                send_beat(($urandom_range(0, 9) < 3) ? MODE_EVICT : MODE_TOUCH, s);
                sent++;
            end else if (kind < 8) begin
                // run of evicts, walks the head around the ring
                len = $urandom_range(1, 20);
                repeat (len) send_beat(MODE_EVICT, t_slot'($urandom));
                sent += len;
            end else if (kind == 8) begin
                // same slot again: already most recent
                len = $urandom_range(2, 4);
                repeat (len) send_beat(MODE_TOUCH, s);
                sent += len;
            end else begin
                len = $urandom_range(2, 16);
                repeat (len) begin
                    send_beat(MODE_TOUCH, s);
                    s = s + 1'b1;
                end
                sent += len;
            end
        end
    endtask

    initial begin
        int wait_cnt;
        wait_cnt = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(MODE_TOUCH, 4'd0);
        send_beat(MODE_TOUCH, 4'd15);
        send_beat(MODE_TOUCH, 4'd15);
        send_beat(MODE_EVICT, 4'd15);
        send_beat(MODE_EVICT, 4'd0);
        send_beat(MODE_TOUCH, 4'd3);
        send_beat(MODE_TOUCH, 4'd10);
        send_beat(MODE_TOUCH, 4'd5);
        send_beat(MODE_TOUCH, 4'd1);
        send_beat(MODE_TOUCH, 4'd2);
        send_beat(MODE_TOUCH, 4'd4);
        send_beat(MODE_TOUCH, 4'd8);
        send_beat(MODE_TOUCH, 4'd0);
        send_beat(MODE_EVICT, 4'd0);
        send_beat(MODE_EVICT, 4'd15);
        send_beat(MODE_EVICT, 4'd5);
        send_beat(MODE_EVICT, 4'd10);
        send_beat(MODE_TOUCH, 4'd15);
        send_beat(MODE_EVICT, 4'd7);
        send_beat(MODE_TOUCH, 4'd7);

        hold_reqs++;
        run_random(PHASE_ITEMS);
        send_idle  = 82;
        recv_stall = 0;
        run_random(PHASE_ITEMS);
        send_idle  = 0;
        recv_stall = 82;
        run_random(PHASE_ITEMS);
        send_idle  = 29;
        recv_stall = 29;
        run_random(PHASE_ITEMS);
        i_valid <= 1'b0;

        while (pending != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/lru_pkg.sv
rtl/core/lru_ram.sv
rtl/core/lru_seq.sv
rtl/core/lru_order_list.sv
verif/lru_order_checker.sv
verif/tb_lru_order_list.sv
